// ===== hw/rtl/sphp_pkg.sv =====
package sphp_pkg;

  // Depth of the drop-time ring and the largest usable drop mark.
  localparam int MAX_DROP_MARK = 16;
  localparam int DROP_IDX_W    = (MAX_DROP_MARK > 1) ? $clog2(MAX_DROP_MARK) : 1;
  // Count must hold MAX_DROP_MARK + 1 while it saturates.
  localparam int DROP_CNT_W    = $clog2(MAX_DROP_MARK + 2);

  localparam int TIME_W      = 32;
  localparam int USERS_W     = 20;
  localparam int MARK_W      = 5;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_POOL    = 3'd0,
    CMD_DEPOOL  = 3'd1,
    CMD_LINK    = 3'd2,
    CMD_QUIT    = 3'd3,
    CMD_CONNECT = 3'd4,
    CMD_LOGOFF  = 3'd5,
    CMD_EMPTIED = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_LINKED   = 3'd1,
    ST_ALREADY_POOL = 3'd2,
    ST_NO_ADDR      = 3'd3,
    ST_NOT_POOLED   = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USER_LIMIT      = 3'd0,
    REG_DROP_MARK       = 3'd1,
    REG_DROP_WINDOW     = 3'd2,
    REG_READD_DELAY     = 3'd3,
    REG_REMOVE_SPLIT    = 3'd4,
    REG_READD_CONNECTED = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [USERS_W-1:0] user_limit;
    logic [MARK_W-1:0]  drop_mark;
    logic [TIME_W-1:0]  drop_window;
    logic [TIME_W-1:0]  readd_delay;
    logic               remove_split;
    logic               readd_connected;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [TIME_W-1:0]  now;
    logic [USERS_W-1:0] user_count;
    logic               server_linked;
    logic               has_addresses;
    logic               services_synced;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                pooled_now;
    logic                active_now;
    logic                notify;
  } out_item_t;

  typedef struct packed {
    logic                  push;
    logic [TIME_W-1:0]     now;
    logic [DROP_CNT_W-1:0] mark;
  } ring_req_t;

  typedef struct packed {
    logic              at_mark;
    logic [TIME_W-1:0] oldest;
  } ring_rsp_t;

endpackage

// ===== hw/rtl/sphp_ring.sv =====
module sphp_ring (
  input  logic                clk,
  input  logic                rst,
  input  sphp_pkg::ring_req_t req,
  output sphp_pkg::ring_rsp_t rsp
);

  logic [sphp_pkg::TIME_W-1:0]     times [sphp_pkg::MAX_DROP_MARK];
  logic [sphp_pkg::DROP_IDX_W-1:0] head;
  logic [sphp_pkg::DROP_CNT_W-1:0] count;

  logic [sphp_pkg::DROP_IDX_W-1:0] head_next;
  logic [sphp_pkg::DROP_CNT_W-1:0] count_inc;
  logic [sphp_pkg::DROP_CNT_W-1:0] count_next;
  logic [sphp_pkg::DROP_IDX_W+1:0] front_sum;
  logic [sphp_pkg::DROP_IDX_W+1:0] front_wrap;
  logic [sphp_pkg::DROP_IDX_W-1:0] front;

  localparam logic [sphp_pkg::DROP_CNT_W-1:0] CNT_MAX =
    sphp_pkg::DROP_CNT_W'(sphp_pkg::MAX_DROP_MARK);
  localparam logic [sphp_pkg::DROP_IDX_W+1:0] IDX_SPAN =
    (sphp_pkg::DROP_IDX_W+2)'(sphp_pkg::MAX_DROP_MARK);

  // Next head, count and oldest slot as if this beat pushes a drop.
  always_comb begin
    if (head == sphp_pkg::DROP_IDX_W'(sphp_pkg::MAX_DROP_MARK - 1)) begin
      head_next = '0;
    end else begin
      head_next = head + 1'b1;
    end
    if (count < CNT_MAX) begin
      count_inc = count + 1'b1;
    end else begin
      count_inc = CNT_MAX + 1'b1;
    end
    if (count_inc > req.mark) begin
      count_next = count_inc - 1'b1;
    end else begin
      count_next = count_inc;
    end
    front_sum = (sphp_pkg::DROP_IDX_W+2)'(head_next) + IDX_SPAN
              - (sphp_pkg::DROP_IDX_W+2)'(count_next);
    if (front_sum >= IDX_SPAN) begin
      front_wrap = front_sum - IDX_SPAN;
    end else begin
      front_wrap = front_sum;
    end
    front = front_wrap[sphp_pkg::DROP_IDX_W-1:0];
  end

  // The slot being written this beat is the oldest only when one drop is kept.
  assign rsp.oldest  = (front == head) ? req.now : times[front];
  assign rsp.at_mark = (count_next == req.mark);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (req.push) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      times[head] <= req.now;
    end
  end

endmodule

// ===== hw/rtl/sphp_policy.sv =====
module sphp_policy (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  sphp_pkg::cfg_t      cfg,
  input  sphp_pkg::in_item_t  item,
  output sphp_pkg::out_item_t result
);

  logic                        pooled;
  logic                        active;
  logic [sphp_pkg::TIME_W-1:0] deadline;

  logic                        pooled_next;
  logic                        active_next;
  logic [sphp_pkg::TIME_W-1:0] deadline_next;
  logic                        notify;
  sphp_pkg::status_t           status;
  logic                        is_act;
  logic                        act_mid;
  logic                        limit_on;
  logic [sphp_pkg::DROP_CNT_W-1:0] mark;
  logic [sphp_pkg::TIME_W-1:0] span;
  sphp_pkg::ring_req_t         ring_req;
  sphp_pkg::ring_rsp_t         ring_rsp;

  localparam logic [sphp_pkg::DROP_CNT_W-1:0] MARK_CAP =
    sphp_pkg::DROP_CNT_W'(sphp_pkg::MAX_DROP_MARK);

  sphp_ring u_ring (
    .clk (clk),
    .rst (rst),
    .req (ring_req),
    .rsp (ring_rsp)
  );

  assign is_act   = pooled & active;
  assign limit_on = (cfg.user_limit != '0);
  assign mark     = ((sphp_pkg::DROP_CNT_W+1)'(cfg.drop_mark) > (sphp_pkg::DROP_CNT_W+1)'(MARK_CAP))
                    ? MARK_CAP : sphp_pkg::DROP_CNT_W'(cfg.drop_mark);
  assign span     = item.now - ring_rsp.oldest;

  always_comb begin
    pooled_next   = pooled;
    active_next   = active;
    deadline_next = deadline;
    notify        = 1'b0;
    status        = sphp_pkg::ST_OK;
    act_mid       = is_act;
    ring_req.push = 1'b0;
    ring_req.now  = item.now;
    ring_req.mark = mark;
    unique case (item.cmd)
      sphp_pkg::CMD_POOL: begin
        if (!item.server_linked) begin
          status = sphp_pkg::ST_NOT_LINKED;
        end else if (pooled) begin
          status = sphp_pkg::ST_ALREADY_POOL;
        end else if (!item.has_addresses) begin
          status = sphp_pkg::ST_NO_ADDR;
        end else begin
          pooled_next = 1'b1;
          active_next = 1'b1;
          notify      = 1'b1;
        end
      end
      sphp_pkg::CMD_DEPOOL: begin
        if (!pooled) begin
          status = sphp_pkg::ST_NOT_POOLED;
        end else begin
          pooled_next = 1'b0;
          active_next = 1'b0;
          notify      = 1'b1;
        end
      end
      sphp_pkg::CMD_LINK: begin
        if ((!item.services_synced || cfg.readd_connected) && pooled && !is_act
            && item.has_addresses) begin
          pooled_next = 1'b1;
          active_next = 1'b1;
          notify      = 1'b1;
        end
      end
      sphp_pkg::CMD_QUIT: begin
        if (cfg.remove_split && is_act) begin
          active_next = 1'b0;
          notify      = 1'b1;
          if (!cfg.readd_connected) begin
            pooled_next = 1'b0;
          end
        end
      end
      sphp_pkg::CMD_CONNECT: begin
        if (is_act && limit_on && item.user_count >= cfg.user_limit) begin
          active_next = 1'b0;
          notify      = 1'b1;
        end
      end
      sphp_pkg::CMD_LOGOFF: begin
        if (pooled) begin
          if (limit_on && !is_act && cfg.user_limit > item.user_count) begin
            pooled_next = 1'b1;
            active_next = 1'b1;
            notify      = 1'b1;
            act_mid     = 1'b1;
          end
          if (mark != '0) begin
            ring_req.push = 1'b1;
            if (ring_rsp.at_mark) begin
              // Fast drops: pull out of service until the readd deadline.
              if (act_mid && span <= cfg.drop_window) begin
                deadline_next = item.now + cfg.readd_delay;
                active_next   = 1'b0;
                notify        = 1'b1;
              end else if (!act_mid && deadline != '0 && deadline <= item.now) begin
                pooled_next   = 1'b1;
                active_next   = 1'b1;
                deadline_next = '0;
                notify        = 1'b1;
              end
            end
          end
        end
      end
      sphp_pkg::CMD_EMPTIED: begin
        deadline_next = '0;
        pooled_next   = 1'b0;
        active_next   = 1'b0;
        notify        = 1'b1;
      end
      default: begin
      end
    endcase
    ring_req.push = ring_req.push & advance;
  end

  assign result.status     = status;
  assign result.pooled_now = pooled_next;
  assign result.active_now = pooled_next & active_next;
  assign result.notify     = notify;

  always_ff @(posedge clk) begin
    if (rst) begin
      pooled   <= 1'b0;
      active   <= 1'b0;
      deadline <= '0;
    end else if (advance) begin
      pooled   <= pooled_next;
      active   <= active_next;
      deadline <= deadline_next;
    end
  end

endmodule

// ===== hw/rtl/server_pool_health_policy_top.sv =====
// Channel | Dir | Handshake           | Payload
// s_      | in  | s_tvalid / s_tready | s_tdata: one event
// m_      | out | m_tvalid / m_tready | m_tdata: one result per event
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data: register write
//
// One event per cycle sustained while m_ is not stalled. An event is held in the input
// register and is resolved against pool state on the way to the result
// register, from which its result is presented on m_.
// Reset (rst, synchronous) empties both stages, clears pool flags, deadline,
// drop ring pointers and all configuration. A stalled m_ side holds the result;
// the input register still takes one more beat before s_tready drops.
module server_pool_health_policy_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [2:0] cmd, [34:3] now, [54:35] user_count, [55] server_linked,
  // [56] has_addresses, [57] services_synced, [63:58] zero
  input  logic [sphp_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [2:0] status, [3] pooled_now, [4] active_now, [5] notify, [7:6] zero
  output logic [sphp_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sphp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sphp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  sphp_pkg::cfg_t      cfg;
  sphp_pkg::in_item_t  in_item;
  sphp_pkg::out_item_t result;
  sphp_pkg::out_item_t out_item;
  logic                in_valid;
  logic                advance;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sphp_pkg::REG_USER_LIMIT:      cfg.user_limit      <= cfg_data[sphp_pkg::USERS_W-1:0];
        sphp_pkg::REG_DROP_MARK:       cfg.drop_mark       <= cfg_data[sphp_pkg::MARK_W-1:0];
        sphp_pkg::REG_DROP_WINDOW:     cfg.drop_window     <= cfg_data[sphp_pkg::TIME_W-1:0];
        sphp_pkg::REG_READD_DELAY:     cfg.readd_delay     <= cfg_data[sphp_pkg::TIME_W-1:0];
        sphp_pkg::REG_REMOVE_SPLIT:    cfg.remove_split    <= cfg_data[0];
        sphp_pkg::REG_READD_CONNECTED: cfg.readd_connected <= cfg_data[0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Move the held event into the result register whenever that register
  // is empty or being drained this cycle.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // Unpack the beat; payload needs no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd             <= s_tdata[2:0];
      in_item.now             <= s_tdata[34:3];
      in_item.user_count      <= s_tdata[54:35];
      in_item.server_linked   <= s_tdata[55];
      in_item.has_addresses   <= s_tdata[56];
      in_item.services_synced <= s_tdata[57];
    end
  end

  sphp_policy u_policy (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .item    (in_item),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  assign m_tdata = {2'b00, out_item.notify, out_item.active_now,
                    out_item.pooled_now, out_item.status};

  // An active result always belongs to a pooled server.
  a_active_implies_pooled : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_item.pooled_now || !out_item.active_now))
    else $error("active result without pooled flag");

  // A refused admin request never touches the activation.
  a_status_no_notify : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_item.status != sphp_pkg::ST_OK) |-> !out_item.notify)
    else $error("error status with notify set");

  // Backpressure on the input only when an event is already held.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled while a stage is free");

  // A held event moves on in the cycle after the result register frees up.
  a_no_lost_event : assert property (@(posedge clk) disable iff (rst)
    (advance && !(s_tvalid && s_tready)) |=> !in_valid)
    else $error("input stage not released after advance");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import sphp_pkg::*;

  // Command code 7 has no meaning; the block must leave its state alone.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned RAND_PHASES  = 9;
  localparam int unsigned PHASE_EVENTS = 155;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // [2:0] cmd, [34:3] now, [54:35] user_count, [55] server_linked,
  // [56] has_addresses, [57] services_synced, [63:58] zero
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // [2:0] status, [3] pooled_now, [4] active_now, [5] notify, [7:6] zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  server_pool_health_policy_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Pool policy predictor. Written only by the scoreboard process at the
  // rising edge where a beat or a register write is taken.
  // ---------------------------------------------------------------------------
  cfg_t                  policy     = '0;
  logic                  pool_flag  = 1'b0;
  logic                  serve_flag = 1'b0;
  logic [TIME_W-1:0]     repool_at  = '0;
  logic [TIME_W-1:0]     drop_stamp [MAX_DROP_MARK];
  logic [DROP_IDX_W-1:0] stamp_head = '0;
  int unsigned           stamp_count = 0;
  logic                  serve_touched;

  out_item_t   expected_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Stimulus side state, owned by the initial block.
  int unsigned        burst_left  = 0;
  logic               steady_send = 1'b0;
  logic [TIME_W-1:0]  wall_now    = '0;
  logic [USERS_W-1:0] cur_limit   = '0;
  int unsigned        hold_asks   = 0;

  // Receiver side state, owned by the ready process.
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  logic [15:0] rx_cycle  = '0;

  // Append a predicted result behind the ones already waiting.
  function automatic void expect_add(input out_item_t r);
    expected_results = {expected_results, r};
  endfunction

  // Take the oldest predicted result.
  function automatic out_item_t expect_take();
    out_item_t r;
    r = expected_results[0];
    expected_results.delete(0);
    return r;
  endfunction

  // Write the activation; turning it on also puts the server in the pool.
  function automatic void set_serving(input logic on);
    if (on) pool_flag = 1'b1;
    serve_flag    = on;
    serve_touched = 1'b1;
  endfunction

  // Depooling always clears the activation too, so it always notifies.
  function automatic void leave_pool();
    set_serving(1'b0);
    pool_flag = 1'b0;
  endfunction

  function automatic out_item_t resolve_event(input in_item_t ev);
    out_item_t             res;
    int unsigned           eff_mark;
    logic [DROP_IDX_W-1:0] front;
    logic [TIME_W-1:0]     age;
    res           = '0;
    res.status    = ST_OK;
    serve_touched = 1'b0;
    case (ev.cmd)
      CMD_POOL: begin
        // Checks go: not linked, already pooled, no addresses.
        if (!ev.server_linked) res.status = ST_NOT_LINKED;
        else if (pool_flag) res.status = ST_ALREADY_POOL;
        else if (!ev.has_addresses) res.status = ST_NO_ADDR;
        else set_serving(1'b1);
      end
      CMD_DEPOOL: begin
        if (!pool_flag) res.status = ST_NOT_POOLED;
        else leave_pool();
      end
      CMD_LINK: begin
        if ((!ev.services_synced || policy.readd_connected) && pool_flag &&
            !(pool_flag && serve_flag) && ev.has_addresses) begin
          set_serving(1'b1);
        end
      end
      CMD_QUIT: begin
        if (policy.remove_split && pool_flag && serve_flag) begin
          if (policy.readd_connected) set_serving(1'b0);
          else leave_pool();
        end
      end
      CMD_CONNECT: begin
        if (pool_flag && serve_flag && policy.user_limit != 0 &&
            ev.user_count >= policy.user_limit) begin
          set_serving(1'b0);
        end
      end
      CMD_LOGOFF: begin
        if (pool_flag) begin
          if (policy.user_limit != 0 && !(pool_flag && serve_flag) &&
              policy.user_limit > ev.user_count) begin
            set_serving(1'b1);
          end
          // Marks above the ring depth saturate to the ring depth.
          eff_mark = (policy.drop_mark > MAX_DROP_MARK) ? MAX_DROP_MARK : policy.drop_mark;
          if (eff_mark != 0) begin
            drop_stamp[stamp_head] = ev.now;
            stamp_head  = stamp_head + 1'b1;
            stamp_count = (stamp_count < MAX_DROP_MARK) ? stamp_count + 1 : MAX_DROP_MARK + 1;
            // Shed at most one oldest entry per logoff; a lowered mark lags.
            if (stamp_count > eff_mark) stamp_count--;
            if (stamp_count == eff_mark) begin
              front = stamp_head - DROP_IDX_W'(stamp_count);
              age   = ev.now - drop_stamp[front];
              if (pool_flag && serve_flag && age <= policy.drop_window) begin
                // Deadline wraps; a sum of zero means nothing pending.
                repool_at = ev.now + policy.readd_delay;
                set_serving(1'b0);
              end else if (!(pool_flag && serve_flag) && repool_at != 0 &&
                           repool_at <= ev.now) begin
                set_serving(1'b1);
                repool_at = '0;
              end
            end
          end
        end
      end
      CMD_EMPTIED: begin
        repool_at = '0;
        leave_pool();
      end
      default: begin
      end
    endcase
    res.pooled_now = pool_flag;
    res.active_now = pool_flag && serve_flag;
    res.notify     = serve_touched;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: check the result beat first, then apply register writes and
  // predict the input beat taken at this same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_item_t  ev;
    out_item_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("server_pool_health_policy_top: mismatch");
      $finish;
    end else if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = expect_take();
          if (m_tdata[2:0] !== want.status || m_tdata[3] !== want.pooled_now ||
              m_tdata[4] !== want.active_now || m_tdata[5] !== want.notify) begin
            $display("%0t: status/pooled/active/notify expected %0d/%0b/%0b/%0b actual %0d/%0b/%0b/%0b",
                     $time, want.status, want.pooled_now, want.active_now, want.notify,
                     m_tdata[2:0], m_tdata[3], m_tdata[4], m_tdata[5]);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_USER_LIMIT:      policy.user_limit      = cfg_data[USERS_W-1:0];
          REG_DROP_MARK:       policy.drop_mark       = cfg_data[MARK_W-1:0];
          REG_DROP_WINDOW:     policy.drop_window     = cfg_data;
          REG_READD_DELAY:     policy.readd_delay     = cfg_data;
          REG_REMOVE_SPLIT:    policy.remove_split    = cfg_data[0];
          REG_READD_CONNECTED: policy.readd_connected = cfg_data[0];
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready) begin
        ev.cmd             = s_tdata[2:0];
        ev.now             = s_tdata[34:3];
        ev.user_count      = s_tdata[54:35];
        ev.server_linked   = s_tdata[55];
        ev.has_addresses   = s_tdata[56];
        ev.services_synced = s_tdata[57];
        expect_add(resolve_event(ev));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: cycle through free, light, heavy and periodic stall patterns.
  // A request from the stimulus side starts a long hold-off, counted here.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      case (rx_cycle[8:7])
        2'd0:    m_tready <= 1'b1;
        2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (rx_cycle % 5) < 2;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps. Valid stays high from
  // one beat to the next inside a burst; it only drops for a real gap.
  // ---------------------------------------------------------------------------
  task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] at,
                            input logic [USERS_W-1:0] users, input logic linked,
                            input logic has_addr, input logic synced);
    int unsigned gap;
    gap = 0;
    if (!steady_send && burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = $urandom_range(1, 24);
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, synced, has_addr, linked, users, at, cmd};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (burst_left != 0) burst_left--;
  endtask

  // Drop valid, let every expected result arrive, then let the pipe settle.
  task automatic wait_drained();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all six registers while the block is idle.
  task automatic load_policy(input cfg_t p);
    reg_idx_t              idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx = '{REG_USER_LIMIT, REG_DROP_MARK, REG_DROP_WINDOW, REG_READD_DELAY,
            REG_REMOVE_SPLIT, REG_READD_CONNECTED};
    val = '{CFG_DATA_W'(p.user_limit), CFG_DATA_W'(p.drop_mark), p.drop_window,
            p.readd_delay, CFG_DATA_W'(p.remove_split), CFG_DATA_W'(p.readd_connected)};
    wait_drained();
    cur_limit = p.user_limit;
    foreach (idx[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly plausible traffic: logoffs and connects with a slowly advancing
  // clock, users near the limit, and a thin layer of admin events and noise.
  task automatic send_random_event();
    int unsigned        pick;
    logic [CMD_W-1:0]   cmd;
    logic [USERS_W-1:0] users;
    logic [TIME_W-1:0]  at;
    pick = $urandom_range(0, 99);
    if (pick < 36) cmd = CMD_LOGOFF;
    else if (pick < 56) cmd = CMD_CONNECT;
    else if (pick < 68) cmd = CMD_POOL;
    else if (pick < 78) cmd = CMD_LINK;
    else if (pick < 86) cmd = CMD_QUIT;
    else if (pick < 91) cmd = CMD_DEPOOL;
    else if (pick < 94) cmd = CMD_EMPTIED;
    else if (pick < 97) cmd = CMD_UNUSED;
    else cmd = CMD_W'($urandom_range(0, 7));
    wall_now = wall_now + (($urandom_range(0, 15) == 0) ? $urandom_range(0, 200)
                                                         : $urandom_range(0, 3));
    at = ($urandom_range(0, 49) == 0) ? $urandom : wall_now;
    if (cur_limit != 0 && $urandom_range(0, 3) != 0)
      users = USERS_W'(cur_limit + $urandom_range(0, 2) - 1);
    else
      users = USERS_W'($urandom_range(0, 20'hFFFFF));
    send_event(cmd, at, users, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
               1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Admin pool and depool status codes, unknown command, and field extremes.
  task automatic test_admin_status();
    cfg_t p;
    p = '0;
    load_policy(p);
    send_event(CMD_POOL,    32'd0,          20'd0,       1'b0, 1'b0, 1'b0);
    send_event(CMD_POOL,    32'd1,          20'd1,       1'b1, 1'b0, 1'b0);
    send_event(CMD_DEPOOL,  32'd2,          20'd0,       1'b1, 1'b1, 1'b1);
    send_event(CMD_POOL,    32'd3,          20'd0,       1'b1, 1'b1, 1'b0);
    send_event(CMD_POOL,    32'hFFFF_FFFF,  20'hFFFFF,   1'b1, 1'b1, 1'b1);
    send_event(CMD_UNUSED,  32'hFFFF_FFFF,  20'hFFFFF,   1'b1, 1'b1, 1'b1);
    send_event(CMD_QUIT,    32'd5,          20'd0,       1'b0, 1'b1, 1'b1);
    send_event(CMD_DEPOOL,  32'd6,          20'd0,       1'b1, 1'b1, 1'b1);
    send_event(CMD_EMPTIED, 32'd7,          20'd0,       1'b1, 1'b0, 1'b0);
  endtask

  // Delink handling: quit deactivates or depools, link reactivates.
  task automatic test_link_quit();
    cfg_t p;
    p                 = '0;
    p.remove_split    = 1'b1;
    p.readd_connected = 1'b1;
    load_policy(p);
    send_event(CMD_POOL, 32'd10, 20'd0, 1'b1, 1'b1, 1'b1);
    send_event(CMD_QUIT, 32'd11, 20'd0, 1'b0, 1'b1, 1'b1);
    send_event(CMD_LINK, 32'd12, 20'd0, 1'b1, 1'b1, 1'b1);
    p.readd_connected = 1'b0;
    load_policy(p);
    send_event(CMD_QUIT, 32'd13, 20'd0, 1'b0, 1'b1, 1'b1);
  endtask

  // User limit at its top value: connect at the limit, logoff below it.
  task automatic test_user_limit();
    cfg_t p;
    p            = '0;
    p.user_limit = 20'hFFFFF;
    load_policy(p);
    send_event(CMD_POOL,    32'd20, 20'd0,     1'b1, 1'b1, 1'b0);
    send_event(CMD_CONNECT, 32'd21, 20'hFFFFF, 1'b1, 1'b1, 1'b0);
    send_event(CMD_LOGOFF,  32'd22, 20'hFFFFE, 1'b1, 1'b1, 1'b0);
  endtask

  // Fast drops: trip, repool after the delay, a deadline that wraps to zero,
  // and a mark lowered below the ring count.
  task automatic test_fast_drop();
    cfg_t p;
    p             = '0;
    p.drop_mark   = 5'd2;
    p.drop_window = 32'd5;
    p.readd_delay = 32'd10;
    load_policy(p);
    send_event(CMD_POOL,   32'd99,  20'd0, 1'b1, 1'b1, 1'b1);
    send_event(CMD_LOGOFF, 32'd100, 20'd0, 1'b1, 1'b1, 1'b1);
    send_event(CMD_LOGOFF, 32'd103, 20'd0, 1'b1, 1'b1, 1'b1);
    send_event(CMD_LOGOFF, 32'd120, 20'd0, 1'b1, 1'b1, 1'b1);
    // 125 plus this delay is 2^32, so no repool gets scheduled.
    p.readd_delay = 32'hFFFF_FFFF - 32'd124;
    load_policy(p);
    send_event(CMD_LOGOFF, 32'd125, 20'd0, 1'b1, 1'b1, 1'b1);
    send_event(CMD_LOGOFF, 32'd126, 20'd0, 1'b1, 1'b1, 1'b1);
    p.drop_mark = 5'd1;
    load_policy(p);
    send_event(CMD_LOGOFF, 32'd130, 20'd0, 1'b1, 1'b1, 1'b1);
  endtask

  // Hold the result side off for a long stretch while beats keep coming,
  // so both stages fill and s_tready drops.
  task automatic test_backpressure();
    cfg_t p;
    p             = '0;
    p.user_limit  = 20'd3;
    p.drop_mark   = 5'd3;
    p.drop_window = 32'd8;
    p.readd_delay = 32'd4;
    load_policy(p);
    wall_now    = 32'd5000;
    steady_send = 1'b1;
    hold_asks  <= hold_asks + 1;
    send_event(CMD_POOL, wall_now, 20'd0, 1'b1, 1'b1, 1'b1);
    repeat (29) send_random_event();
    steady_send = 1'b0;
  endtask

  // Random phases, each under its own policy; the first two use the extremes.
  task automatic test_random_traffic();
    cfg_t p;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        p = '{user_limit: 20'hFFFFF, drop_mark: 5'd31, drop_window: 32'hFFFF_FFFF,
              readd_delay: 32'hFFFF_FFFF, remove_split: 1'b1, readd_connected: 1'b1};
      end else if (ph == 1) begin
        p = '0;
      end else begin
        case ($urandom_range(0, 3))
          0:       p.user_limit = '0;
          1:       p.user_limit = USERS_W'($urandom_range(1, 8));
          2:       p.user_limit = USERS_W'($urandom_range(1, 64));
          default: p.user_limit = USERS_W'($urandom_range(0, 20'hFFFFF));
        endcase
        case ($urandom_range(0, 5))
          0:       p.drop_mark = 5'd0;
          4:       p.drop_mark = MARK_W'($urandom_range(7, 16));
          5:       p.drop_mark = MARK_W'($urandom_range(17, 31));
          default: p.drop_mark = MARK_W'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 3))
          0:       p.drop_window = '0;
          1:       p.drop_window = $urandom_range(1, 20);
          2:       p.drop_window = 32'hFFFF_FFFF;
          default: p.drop_window = $urandom;
        endcase
        case ($urandom_range(0, 3))
          0:       p.readd_delay = '0;
          1:       p.readd_delay = $urandom_range(1, 30);
          2:       p.readd_delay = 32'hFFFF_FFFF;
          default: p.readd_delay = $urandom;
        endcase
        p.remove_split    = 1'($urandom_range(0, 1));
        p.readd_connected = 1'($urandom_range(0, 1));
      end
      load_policy(p);
      // Start the clock low, anywhere, or just short of wrapping.
      case ($urandom_range(0, 2))
        0:       wall_now = $urandom_range(0, 1000);
        1:       wall_now = $urandom;
        default: wall_now = 32'hFFFF_FFFF - $urandom_range(0, 300);
      endcase
      repeat (PHASE_EVENTS) send_random_event();
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_admin_status();
    test_link_quit();
    test_user_limit();
    test_fast_drop();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("server_pool_health_policy_top: match");
    end else begin
      $display("server_pool_health_policy_top: mismatch");
    end
    $finish;
  end

endmodule
